FILE: hdl/block_map_allocator_unit_macros.svh
// ---------------------------------------------------------------------------
// Block map allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ---------------------------------------------------------------------------
`ifndef BLOCK_MAP_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_MAP_ALLOCATOR_UNIT_MACROS_SVH

// Generic clocked assertion, disabled while reset is held low.
`define BMA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define BMA_ASSERT_CLK(lbl, prop, msg) \
  `BMA_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/bma_pkg.sv
// ---------------------------------------------------------------------------
// Block map allocator package
// Sizes, map codes, status codes and the map access bundle.
// ---------------------------------------------------------------------------
package bma_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned NUM_BLOCKS  = 256;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned MAP_W     = 8;
  localparam int unsigned IDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned OFF_SHIFT = $clog2(BLOCK_BYTES);
  localparam int unsigned NEED_W    = SIZE_W + 1;

  // Byte span of the whole heap, computed without wrap.
  localparam logic [ADDR_W:0] HEAP_SPAN = (ADDR_W + 1)'(NUM_BLOCKS * BLOCK_BYTES);

  localparam logic [MAP_W-1:0] MAP_FREE = 8'h00;
  localparam logic [MAP_W-1:0] MAP_CONT = 8'hFF;
  localparam int unsigned      MAX_RUN  = 254;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_ZERO       = 3'd1;
  localparam status_t ST_TOO_LARGE  = 3'd2;
  localparam status_t ST_NO_ROOM    = 3'd3;
  localparam status_t ST_OUTSIDE    = 3'd4;
  localparam status_t ST_MISALIGNED = 3'd5;
  localparam status_t ST_NOT_HEAD   = 3'd6;
  localparam status_t ST_CORRUPT    = 3'd7;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [MAP_W-1:0] wr_data;
    logic             clr_en;
    logic [IDX_W-1:0] clr_addr;
  } map_req_t;

endpackage

FILE: hdl/bma_if.sv
// ---------------------------------------------------------------------------
// Block map allocator channels
// Valid/ready channels for configuration, commands and responses.
// ---------------------------------------------------------------------------
interface bma_cfg_if import bma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] heap_base;

  modport source (output valid, output heap_base, input ready);
  modport sink   (input valid, input heap_base, output ready);
endinterface

interface bma_cmd_if import bma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output size_bytes, output address,
                  input ready);
  modport sink   (input valid, input command, input size_bytes, input address,
                  output ready);
endinterface

interface bma_rsp_if import bma_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ADDR_W-1:0] alloc_address;

  modport source (output valid, output status, output alloc_address, input ready);
  modport sink   (input valid, input status, input alloc_address, output ready);
endinterface

FILE: hdl/bma_map_mem.sv
// ---------------------------------------------------------------------------
// Block map store
// One entry per heap block; per-entry valid flags make reset read as free.
// ---------------------------------------------------------------------------
module bma_map_mem import bma_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  map_req_t         req_i,
  output logic [MAP_W-1:0] rd_data_o
);

  logic [MAP_W-1:0]      mem [NUM_BLOCKS];
  logic [MAP_W-1:0]      rdata_q;
  logic [NUM_BLOCKS-1:0] valid_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  // Set on write, drop on release; a dropped entry reads as free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.clr_en) begin
        valid_q[req_i.clr_addr] <= 1'b0;
      end
      if (req_i.rd_en) begin
        rvld_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : MAP_FREE;

endmodule

FILE: hdl/block_map_allocator_unit.sv
// ---------------------------------------------------------------------------
// Block map allocator unit
// First-fit fixed-block heap manager driven by a small sequencer.
// ---------------------------------------------------------------------------
// Channels: cfg_i takes the heap base word and is always ready, so write it
//   only while no command is in flight; cmd_i takes one command word
//   (allocate a byte size, or free an address) and is ready only while the
//   sequencer is idle; rsp_o returns one word per command: status plus the
//   allocated address (zero on any failure and on every free).
// Sequence, accept to response valid:
//   allocate: a check, a scan of one entry a cycle, a write to each block
//     of the run, an output load; no room after a full scan, zero or
//     oversized refused at the check.
//   free: an address check, a head read, a clear of each block of the run,
//     an output load; a refused address ends at the check, a non-head
//     entry or a run past the map end after the head read.
// Throughput: one command at a time; the next is taken the cycle after the
//   response is loaded.
// Reset: clears the map (all blocks free) and loads the default heap base.
// Stall: a pending response holds in the output register; a finished
//   command waits in its final state until that register frees up.
// ---------------------------------------------------------------------------
module block_map_allocator_unit import bma_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bma_cfg_if.sink      cfg_i,
  bma_cmd_if.sink      cmd_i,
  bma_rsp_if.source    rsp_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FREAD = 3'd4;
  localparam logic [2:0] S_FHEAD = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'h2000_1000;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] heap_base_q;

  // Latched command word
  logic              cmd_q, cmd_d;
  logic              zero_q, zero_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  // Scan, mark and clear bookkeeping
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              p_vld_q, p_vld_d;
  logic [IDX_W-1:0]  p_idx_q, p_idx_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  base_idx_q, base_idx_d;
  logic [MAP_W-1:0]  head_q, head_d;

  // Result pending transfer into the output register
  status_t           res_st_q, res_st_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;

  // Output register
  logic              out_vld_q;
  status_t           out_st_q;
  logic [ADDR_W-1:0] out_addr_q;

  map_req_t          map_req;
  logic [MAP_W-1:0]  map_rdata;

  logic              cmd_acc;
  logic              out_load;
  logic [ADDR_W:0]   diff;
  logic [CNT_W-1:0]  run_inc;
  logic [CNT_W-1:0]  start_w;
  logic [CNT_W:0]    run_end;

  bma_map_mem u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .rd_data_o (map_rdata)
  );

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign out_load    = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);

  // Free range check: one subtract, borrow flags an address below the base.
  assign diff    = {1'b0, addr_q} - {1'b0, heap_base_q};
  assign run_inc = run_q + CNT_W'(1);
  assign start_w = CNT_W'(p_idx_q) + CNT_W'(1) - CNT_W'(need_q);
  assign run_end = (CNT_W + 1)'(base_idx_q) + (CNT_W + 1)'(map_rdata);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    zero_d     = zero_q;
    need_d     = need_q;
    addr_d     = addr_q;
    iss_d      = iss_q;
    p_vld_d    = 1'b0;
    p_idx_d    = p_idx_q;
    run_d      = run_q;
    cnt_d      = cnt_q;
    base_idx_d = base_idx_q;
    head_d     = head_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    map_req    = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_acc) begin
          cmd_d   = cmd_i.command;
          zero_d  = (cmd_i.size_bytes == '0);
          // round up to whole blocks
          need_d  = NEED_W'(({1'b0, cmd_i.size_bytes} + NEED_W'(BLOCK_BYTES - 1))
                            >> OFF_SHIFT);
          addr_d  = cmd_i.address;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        res_addr_d = '0;
        state_d    = S_DONE;
        if (cmd_q == CMD_ALLOC) begin
          if (zero_q) begin
            res_st_d = ST_ZERO;
          end else if (need_q > NEED_W'(MAX_RUN)) begin
            res_st_d = ST_TOO_LARGE;
          end else if (need_q > NEED_W'(NUM_BLOCKS)) begin
            res_st_d = ST_NO_ROOM;
          end else begin
            iss_d   = '0;
            run_d   = '0;
            state_d = S_SCAN;
          end
        end else begin
          if (addr_q == '0 || diff[ADDR_W]) begin
            res_st_d = ST_OUTSIDE;
          end else if (diff >= HEAP_SPAN) begin
            res_st_d = ST_OUTSIDE;
          end else if (OFF_SHIFT > 0 && (diff & (ADDR_W + 1)'(BLOCK_BYTES - 1)) != '0) begin
            res_st_d = ST_MISALIGNED;
          end else begin
            base_idx_d = IDX_W'(diff >> OFF_SHIFT);
            state_d    = S_FREAD;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle, evaluate the entry read last cycle.
        if (iss_q < CNT_W'(NUM_BLOCKS)) begin
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = iss_q[IDX_W-1:0];
          iss_d           = iss_q + CNT_W'(1);
          p_vld_d         = 1'b1;
          p_idx_d         = iss_q[IDX_W-1:0];
        end
        if (p_vld_q) begin
          if (map_rdata == MAP_FREE) begin
            run_d = run_inc;
            if (NEED_W'(run_inc) == need_q) begin
              base_idx_d = start_w[IDX_W-1:0];
              cnt_d      = '0;
              p_vld_d    = 1'b0;
              state_d    = S_MARK;
            end
          end else begin
            run_d = '0;
          end
          if (state_d == S_SCAN && p_idx_q == IDX_W'(NUM_BLOCKS - 1)) begin
            res_st_d = ST_NO_ROOM;
            state_d  = S_DONE;
          end
        end
      end

      S_MARK: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = base_idx_q + cnt_q[IDX_W-1:0];
        map_req.wr_data = (cnt_q == '0) ? MAP_W'(need_q) : MAP_CONT;
        cnt_d           = cnt_q + CNT_W'(1);
        if (NEED_W'(cnt_d) == need_q) begin
          res_st_d   = ST_OK;
          res_addr_d = heap_base_q + (ADDR_W'(base_idx_q) << OFF_SHIFT);
          state_d    = S_DONE;
        end
      end

      S_FREAD: begin
        map_req.rd_en   = 1'b1;
        map_req.rd_addr = base_idx_q;
        state_d         = S_FHEAD;
      end

      S_FHEAD: begin
        if (map_rdata == MAP_FREE || map_rdata == MAP_CONT) begin
          res_st_d = ST_NOT_HEAD;
          state_d  = S_DONE;
        end else if (run_end > (CNT_W + 1)'(NUM_BLOCKS)) begin
          res_st_d = ST_CORRUPT;
          state_d  = S_DONE;
        end else begin
          head_d  = map_rdata;
          cnt_d   = '0;
          state_d = S_CLEAR;
        end
      end

      S_CLEAR: begin
        map_req.clr_en   = 1'b1;
        map_req.clr_addr = base_idx_q + cnt_q[IDX_W-1:0];
        cnt_d            = cnt_q + CNT_W'(1);
        if (cnt_d == CNT_W'(head_q)) begin
          res_st_d = ST_OK;
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_base_q <= HEAP_BASE_RST;
      p_vld_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      p_vld_q <= p_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        heap_base_q <= cfg_i.heap_base;
      end
      // Hold the word until taken; reload straight from the sequencer.
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    zero_q     <= zero_d;
    need_q     <= need_d;
    addr_q     <= addr_d;
    iss_q      <= iss_d;
    p_idx_q    <= p_idx_d;
    run_q      <= run_d;
    cnt_q      <= cnt_d;
    base_idx_q <= base_idx_d;
    head_q     <= head_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    if (out_load) begin
      out_st_q   <= res_st_q;
      out_addr_q <= res_addr_q;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_st_q;
  assign rsp_o.alloc_address = out_addr_q;

endmodule

FILE: hdl/bma_checker.sv
// ---------------------------------------------------------------------------
// Block map allocator port checker
// Port-level properties of the allocator, attached by bind.
// ---------------------------------------------------------------------------
`include "block_map_allocator_unit_macros.svh"

module bma_checker import bma_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cmd_valid_i,
  input logic              cmd_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input status_t           rsp_status_i,
  input logic [ADDR_W-1:0] rsp_addr_i
);

  // A stalled response word holds.
  `BMA_ASSERT_CLK(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_addr_i), "response changed while stalled")

  // Any failure carries a zero address.
  `BMA_ASSERT_CLK(a_fail_zero_addr, rsp_valid_i && rsp_status_i != ST_OK |-> rsp_addr_i == '0, "failed command returned an address")

  // A command word keeps the sequencer busy on the next cycle.
  `BMA_ASSERT_CLK(a_busy_after_accept, cmd_valid_i && cmd_ready_i |=> !cmd_ready_i, "command port ready right after accept")

endmodule

bind block_map_allocator_unit bma_checker u_bma_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_addr_i   (rsp_o.alloc_address)
);
